/* design/sqbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqbt_pkg: shared types and helpers of the send queue boundary tracker
// Field widths, command and status codes, cell control, serial compares.
// ----------------------------------------------------------------------------
package sqbt_pkg;

    localparam int SEQ_W         = 32;
    localparam int LEN_W         = 16;
    localparam int TAG_W         = 16;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT    = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_SEGMENT = 2'd2,
        CMD_DISCARD = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_SEG,
        S_DISC
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0] end_seq;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // Per-cell control: load the new message, shift toward the head,
    // and take the head entry instead of the neighbor (tail of the ring).
    typedef struct packed {
        logic load;
        logic shift;
        logic wrap;
    } t_cell_ctrl;

    // a is before b in 32-bit serial arithmetic
    function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                        input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

    function automatic logic seq_not_after(input logic [SEQ_W-1:0] a,
                                           input logic [SEQ_W-1:0] b);
        return (a == b) || seq_before(a, b);
    endfunction

endpackage

/* design/sqbt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqbt_cell: one queue slot of the tracker
// Holds one message word; loads, or takes its neighbor or the head on a shift.
// ----------------------------------------------------------------------------
module sqbt_cell (
    input  logic                i_clk,
    input  sqbt_pkg::t_cell_ctrl i_ctrl,
    input  sqbt_pkg::t_entry    i_next,
    input  sqbt_pkg::t_entry    i_head,
    input  sqbt_pkg::t_entry    i_load,
    output sqbt_pkg::t_entry    o_entry
);
    import sqbt_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_entry <= i_load;
        end else if (i_ctrl.shift) begin
            r_entry <= i_ctrl.wrap ? i_head : i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

/* design/send_queue_boundary_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// send_queue_boundary_tracker: transport send queue with sequence tracking
// Init, enqueue: accepted in idle; the result word is registered from S_EMIT.
// Discard: pops acknowledged messages from the head, one pop per cycle, then
// emits the result word. Segment: rotates the queue past the head, one cell
// rotated per cycle unless a report waits on a stalled output, reporting each
// match. Sync active-low reset clears begin, end, occupancy and control.
// ----------------------------------------------------------------------------
module send_queue_boundary_tracker #(
    parameter int QUEUE_DEPTH = sqbt_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sqbt_pkg::CMD_W-1:0]    i_command,
    input  logic [sqbt_pkg::SEQ_W-1:0]    i_seq,
    input  logic [sqbt_pkg::LEN_W-1:0]    i_length,
    input  logic [sqbt_pkg::TAG_W-1:0]    i_msg_tag,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sqbt_pkg::STATUS_W-1:0] o_status,
    output logic [sqbt_pkg::SEQ_W-1:0]    o_begin_seq,
    output logic [sqbt_pkg::SEQ_W-1:0]    o_end_seq,
    output logic                          o_entry_valid,
    output logic [sqbt_pkg::SEQ_W-1:0]    o_entry_end_seq,
    output logic [sqbt_pkg::TAG_W-1:0]    o_entry_tag,
    output logic                          o_last
);
    import sqbt_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);   // occupancy and scan index
    localparam int NW = $clog2(MAX_RESULTS + 1);   // reported message count

    // control state
    t_state            r_state, n_state;
    logic [SEQ_W-1:0]  r_begin, n_begin;
    logic [SEQ_W-1:0]  r_end, n_end;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_k, n_k;
    logic [NW-1:0]     r_n, n_n;
    logic              r_started, n_started;
    logic              r_done, n_done;
    t_status           r_status, n_status;
    // operands held for a segment or discard walk
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic [SEQ_W-1:0]  r_to, n_to;

    // output register
    logic              r_o_valid;
    t_status           r_o_status;
    logic [SEQ_W-1:0]  r_o_begin;
    logic [SEQ_W-1:0]  r_o_end;
    logic              r_o_entry_valid;
    t_entry            r_o_entry;
    logic              r_o_last;

    // result word to load this cycle
    logic              emit;
    t_status           em_status;
    logic              em_entry_valid;
    t_entry            em_entry;
    logic              em_last;
    logic              out_free;

    // cell row
    logic              do_load;
    logic              do_shift;
    t_entry            load_entry;
    t_entry            w_cells [QUEUE_DEPTH];
    t_entry            head;
    t_entry            second;

    // scratch values of the decode and walk
    logic [SEQ_W-1:0]  enq_end;
    logic [SEQ_W-1:0]  seg_to;
    logic              hit_skip;
    logic              active;
    logic              qual;
    logic              report;
    logic              is_last;

    assign head     = w_cells[0];
    assign second   = w_cells[1];
    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    assign enq_end    = r_end + {{(SEQ_W-LEN_W){1'b0}}, i_length};
    assign seg_to     = i_seq + {{(SEQ_W-LEN_W){1'b0}}, i_length};
    assign load_entry = '{end_seq: enq_end, tag: i_msg_tag};

    // Each cell takes its right neighbor on a shift; the cell at the tail of
    // the occupied part takes the head instead, so a full pass rotates the
    // queue back into place.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_cell_ctrl w_ctrl;
        t_entry     w_next;

        assign w_ctrl.load  = do_load && (r_count == CW'(g));
        assign w_ctrl.shift = do_shift;
        assign w_ctrl.wrap  = (r_count == CW'(g + 1));

        if (g == QUEUE_DEPTH - 1) begin : g_end
            assign w_next = head;
        end else begin : g_mid
            assign w_next = w_cells[g+1];
        end

        sqbt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_next  (w_next),
            .i_head  (head),
            .i_load  (load_entry),
            .o_entry (w_cells[g])
        );
    end

    // segment walk terms, evaluated on the entry now at the head
    assign hit_skip = !r_started && seq_not_after(head.end_seq, r_seq);
    assign active   = !hit_skip && !r_done;
    assign qual     = seq_not_after(head.end_seq, r_to);
    assign report   = active && qual;
    assign is_last  = ((r_k + CW'(1)) == r_count)
                   || !seq_not_after(second.end_seq, r_to)
                   || (NW'(r_n + NW'(1)) == NW'(MAX_RESULTS));

    always_comb begin
        n_state        = r_state;
        n_begin        = r_begin;
        n_end          = r_end;
        n_count        = r_count;
        n_k            = r_k;
        n_n            = r_n;
        n_started      = r_started;
        n_done         = r_done;
        n_status       = r_status;
        n_seq          = r_seq;
        n_to           = r_to;
        do_load        = 1'b0;
        do_shift       = 1'b0;
        emit           = 1'b0;
        em_status      = ST_OK;
        em_entry_valid = 1'b0;
        em_entry       = '0;
        em_last        = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EMIT;
                    unique case (t_cmd'(i_command))
                        CMD_INIT: begin
                            n_begin  = i_seq;
                            n_end    = i_seq;
                            n_status = ST_OK;
                        end
                        CMD_ENQUEUE: begin
                            // reject on wrap past begin or a full row
                            if (seq_before(enq_end, r_begin) ||
                                (r_count == CW'(QUEUE_DEPTH))) begin
                                n_status = ST_FULL;
                            end else begin
                                do_load  = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_end    = enq_end;
                                n_status = ST_OK;
                            end
                        end
                        CMD_SEGMENT: begin
                            if (!seq_not_after(r_begin, i_seq) ||
                                !seq_not_after(seg_to, r_end)) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_seq     = i_seq;
                                n_to      = seg_to;
                                n_k       = '0;
                                n_n       = '0;
                                n_started = 1'b0;
                                n_done    = 1'b0;
                                n_state   = S_SEG;
                            end
                        end
                        CMD_DISCARD: begin
                            if (!seq_not_after(r_begin, i_seq) ||
                                !seq_not_after(i_seq, r_end)) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_begin = i_seq;
                                n_seq   = i_seq;
                                n_state = S_DISC;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_EMIT: begin
                // single word: status with begin and end after the step
                if (out_free) begin
                    emit      = 1'b1;
                    em_status = r_status;
                    n_state   = S_IDLE;
                end
            end

            S_DISC: begin
                // pop one acknowledged message per cycle from the head
                if ((r_count != '0) && seq_not_after(head.end_seq, r_seq)) begin
                    do_shift = 1'b1;
                    n_count  = r_count - CW'(1);
                end else begin
                    n_status = ST_OK;
                    n_state  = S_EMIT;
                end
            end

            S_SEG: begin
                if (r_k == r_count) begin
                    // pass complete; report an empty segment if nothing matched
                    if (r_n == '0) begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (!report || out_free) begin
                    // advance the rotation; hold it while a report waits
                    do_shift = 1'b1;
                    n_k      = r_k + CW'(1);
                    if (!hit_skip) begin
                        n_started = 1'b1;
                    end
                    if (active && !qual) begin
                        n_done = 1'b1;
                    end
                    if (report) begin
                        emit           = 1'b1;
                        em_entry_valid = 1'b1;
                        em_entry       = head;
                        em_last        = is_last;
                        n_n            = NW'(r_n + NW'(1));
                        if (is_last) begin
                            n_done = 1'b1;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_begin   <= '0;
            r_end     <= '0;
            r_count   <= '0;
            r_k       <= '0;
            r_n       <= '0;
            r_started <= 1'b0;
            r_done    <= 1'b0;
            r_status  <= ST_OK;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_begin   <= n_begin;
            r_end     <= n_end;
            r_count   <= n_count;
            r_k       <= n_k;
            r_n       <= n_n;
            r_started <= n_started;
            r_done    <= n_done;
            r_status  <= n_status;
            if (out_free) begin
                r_o_valid <= emit;
            end
        end
    end

    // operands and result payload: no reset
    always_ff @(posedge i_clk) begin
        r_seq <= n_seq;
        r_to  <= n_to;
        if (emit) begin
            r_o_status      <= em_status;
            r_o_begin       <= r_begin;
            r_o_end         <= r_end;
            r_o_entry_valid <= em_entry_valid;
            r_o_entry       <= em_entry;
            r_o_last        <= em_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_begin_seq     = r_o_begin;
    assign o_end_seq       = r_o_end;
    assign o_entry_valid   = r_o_entry_valid;
    assign o_entry_end_seq = r_o_entry.end_seq;
    assign o_entry_tag     = r_o_entry.tag;
    assign o_last          = r_o_last;

endmodule
